// ===== rtl/core/tsrt_pkg.sv =====
// Package for the time-sorted record table: sizes, codes and payload types.
package tsrt_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DELETED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_READ_OK   = 3'd4;
    localparam logic [2:0] ST_BAD_POS   = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] carrier_code;
        logic [13:0] trip_number;
        logic [23:0] origin_code;
        logic [13:0] start_time;
        logic [23:0] dest_code;
        logic [5:0]  position;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  fill_count;
        logic [15:0] rd_carrier;
        logic [13:0] rd_trip;
        logic [23:0] rd_origin;
        logic [13:0] rd_time;
        logic [23:0] rd_dest;
    } t_out;

    typedef struct packed {
        logic [15:0] carrier_code;
        logic [13:0] trip_number;
        logic [23:0] origin_code;
        logic [13:0] start_time;
        logic [23:0] dest_code;
    } t_rec;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_PREV = 2'd2,
        CELL_NEXT = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode  mode;
        logic        slot_valid;
        logic [13:0] cmp_time;
        logic [15:0] cmp_carrier;
        logic [13:0] cmp_trip;
    } t_cell_cmd;

    typedef struct packed {
        logic after;
        logic match;
    } t_cell_flags;

endpackage

// ===== rtl/core/time_sorted_record_table.sv =====
// Top level of the time-sorted record table: control, cell row and result register.
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+--------------------------
//  request  | in        | i_in_valid / o_in_ready  | i_in  (t_in: op and record)
//  result   | out       | o_out_valid / i_out_ready| o_out (t_out: status, count, read data)
//
// Every request passes S_EVAL, in which each cell compares its record with the
// request and the flags are registered, and then S_APPLY, in which the row shifts and
// the result is written to the output register. A new request can be accepted as the
// previous one is applied, but not while that one is still in S_EVAL.
// Reset (synchronous, active low) empties the table and the output register at once.
// A result waiting in the output register does not block the next transfer in; the
// S_APPLY step of the following request waits only while the old result is still held.
module time_sorted_record_table
    import tsrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_in                 r_in;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CAPACITY-1:0] r_after;
    logic [CAPACITY-1:0] r_match;
    t_out                r_out;
    t_out                n_out;
    logic                r_out_valid;

    t_rec                w_rec   [CAPACITY];
    t_cell_cmd           w_cmd   [CAPACITY];
    t_cell_flags         w_flags [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_prev_after;
    logic [CAPACITY-1:0] w_hit_upto;
    t_rec                w_new;
    t_rec                w_sel_rec;

    logic w_out_free;
    logic w_apply;
    logic w_in_acc;
    logic w_ins_ok;
    logic w_found;
    logic w_del;
    logic w_pos_ok;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_apply    = (r_state == S_APPLY) && w_out_free;
    assign o_in_ready = (r_state == S_IDLE) || w_apply;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_ins_ok = (r_in.op == OP_INSERT) && (r_count < CNT_W'(CAPACITY));
    assign w_found  = |r_match;
    assign w_del    = (r_in.op == OP_DELETE) && w_found;
    assign w_pos_ok = (r_in.op == OP_READ) && (CMP_W'(r_in.position) < CMP_W'(r_count));

    assign w_new.carrier_code = r_in.carrier_code;
    assign w_new.trip_number  = r_in.trip_number;
    assign w_new.origin_code  = r_in.origin_code;
    assign w_new.start_time   = r_in.start_time;
    assign w_new.dest_code    = r_in.dest_code;

    // The row of cells. Each cell sees its neighbours; records move up by one place on an
    // insert and down by one place on a delete. Slots at or above the count hold no record.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_valid[g]    = r_count > CNT_W'(g);
        assign w_hit_upto[g] = |r_match[g:0];

        if (g == 0) begin : g_first
            assign w_prev_after[g] = 1'b0;
        end else begin : g_rest
            assign w_prev_after[g] = r_after[g-1];
        end

        always_comb begin
            w_cmd[g].slot_valid  = w_valid[g];
            w_cmd[g].cmp_time    = r_in.start_time;
            w_cmd[g].cmp_carrier = r_in.carrier_code;
            w_cmd[g].cmp_trip    = r_in.trip_number;
            w_cmd[g].mode        = CELL_HOLD;
            if (w_apply) begin
                if (w_ins_ok && r_after[g]) begin
                    // The first slot lying after the new time takes the new record.
                    w_cmd[g].mode = w_prev_after[g] ? CELL_PREV : CELL_LOAD;
                end else if (w_del && w_hit_upto[g]) begin
                    // The first matching slot and all above it close the gap.
                    w_cmd[g].mode = CELL_NEXT;
                end
            end
        end

        if (g == 0 && g == CAPACITY - 1) begin : g_single
            tsrt_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd[g]),
                .i_new   (w_new),
                .i_prev  (w_new),
                .i_next  ('0),
                .o_rec   (w_rec[g]),
                .o_flags (w_flags[g])
            );
        end else if (g == 0) begin : g_head
            tsrt_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd[g]),
                .i_new   (w_new),
                .i_prev  (w_new),
                .i_next  (w_rec[g+1]),
                .o_rec   (w_rec[g]),
                .o_flags (w_flags[g])
            );
        end else if (g == CAPACITY - 1) begin : g_tail
            tsrt_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd[g]),
                .i_new   (w_new),
                .i_prev  (w_rec[g-1]),
                .i_next  ('0),
                .o_rec   (w_rec[g]),
                .o_flags (w_flags[g])
            );
        end else begin : g_mid
            tsrt_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd[g]),
                .i_new   (w_new),
                .i_prev  (w_rec[g-1]),
                .i_next  (w_rec[g+1]),
                .o_rec   (w_rec[g]),
                .o_flags (w_flags[g])
            );
        end

        // The compare flags are captured while the table is still, at the end of S_EVAL.
        always_ff @(posedge i_clk) begin
            if (r_state == S_EVAL) begin
                r_after[g] <= w_flags[g].after;
                r_match[g] <= w_flags[g].match;
            end
        end
    end

    // The read gathers the one selected record by an OR over the row.
    always_comb begin
        w_sel_rec = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CMP_W'(r_in.position) == CMP_W'(k)) begin
                w_sel_rec = w_sel_rec | w_rec[k];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.fill_count = 7'(n_count);
        case (r_in.op)
            OP_INSERT: n_out.status = w_ins_ok ? ST_INSERTED : ST_FULL;
            OP_DELETE: n_out.status = w_found ? ST_DELETED : ST_NOT_FOUND;
            default:   n_out.status = w_pos_ok ? ST_READ_OK : ST_BAD_POS;
        endcase
        if (w_pos_ok) begin
            n_out.rd_carrier = w_sel_rec.carrier_code;
            n_out.rd_trip    = w_sel_rec.trip_number;
            n_out.rd_origin  = w_sel_rec.origin_code;
            n_out.rd_time    = w_sel_rec.start_time;
            n_out.rd_dest    = w_sel_rec.dest_code;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = w_in_acc ? S_EVAL : S_IDLE;
            S_EVAL:  n_state = S_APPLY;
            S_APPLY: begin
                if (w_apply) begin
                    n_state = w_in_acc ? S_EVAL : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in;
        end
        if (w_apply) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/core/tsrt_cell.sv =====
// One table slot: holds a record, compares it with the request and moves it along the row.
module tsrt_cell
    import tsrt_pkg::*;
(
    input  logic        i_clk,
    input  t_cell_cmd   i_cmd,
    input  t_rec        i_new,
    input  t_rec        i_prev,
    input  t_rec        i_next,
    output t_rec        o_rec,
    output t_cell_flags o_flags
);

    t_rec r_rec;
    t_rec n_rec;

    always_comb begin
        n_rec = r_rec;
        unique case (i_cmd.mode)
            CELL_HOLD: n_rec = r_rec;
            CELL_LOAD: n_rec = i_new;
            CELL_PREV: n_rec = i_prev;
            CELL_NEXT: n_rec = i_next;
            default:   n_rec = r_rec;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    // An empty slot counts as lying after any new time, so an insert lands at the end.
    assign o_flags.after = !i_cmd.slot_valid || (r_rec.start_time > i_cmd.cmp_time);
    assign o_flags.match = i_cmd.slot_valid && (r_rec.carrier_code == i_cmd.cmp_carrier)
                           && (r_rec.trip_number == i_cmd.cmp_trip);
    assign o_rec = r_rec;

endmodule
